// ===== hw/rtl/positional_list_engine_top_assert.svh =====
// Assertion macros for the positional list engine top level.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ple_pkg.sv =====
// Shared widths, command and status codes and the cell control struct
// for the positional list engine. No dependencies.
package ple_pkg;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 10;
    localparam int MODE_W  = 3;
    localparam int LEN_W   = 9;
    localparam int ST_W    = 2;
    localparam int GROUP_N = 32;

    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POP       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic load;
        logic up;
        logic down;
        logic sel;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// One storage cell of the list chain: holds one entry, loads a new value
// or takes its lower or upper neighbour's entry. Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_val,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_tap
);

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data <= i_val;
        end else if (i_ctrl.up) begin
            r_data <= i_left;
        end else if (i_ctrl.down) begin
            r_data <= i_right;
        end
    end

    assign o_data = r_data;
    assign o_tap  = i_ctrl.sel ? r_data : '0;

endmodule

// ===== hw/rtl/ple_gather.sv =====
// Two-level registered OR tree that collects the one selected cell tap.
// Depends on ple_pkg.
module ple_gather
    import ple_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [DEPTH-1:0][DATA_W-1:0] i_taps,
    output logic [DATA_W-1:0]           o_word
);

    localparam int GN = (DEPTH + GROUP_N - 1) / GROUP_N;

    logic [GN-1:0][DATA_W-1:0] r_grp;
    logic [GN-1:0][DATA_W-1:0] n_grp;

    for (genvar g = 0; g < GN; g++) begin : g_grp
        localparam int GCNT = (g == GN - 1) ? (DEPTH - g * GROUP_N) : GROUP_N;
        always_comb begin
            n_grp[g] = '0;
            for (int j = 0; j < GCNT; j++) begin
                n_grp[g] = n_grp[g] | i_taps[g * GROUP_N + j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < GN; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

// ===== hw/rtl/positional_list_engine_top.sv =====
// Positional list engine: a chain of entry cells with a length count and a
// registered gather tree for reads. Depends on ple_pkg, ple_cell, ple_gather and the assert header.
//
// Each command item gives exactly one result item. When an item is taken, the
// cell chain shifts, loads or keeps at that same edge, and the selected entry
// is caught in the gather registers. The output register is loaded in the cycle
// after that. Input is held off while a result is pending or unread, so a new
// item is not taken until the last result has left or is leaving. Insert and
// remove move every later entry by one place at once, at the accepting edge.
// A command that fails leaves the list unchanged. Length is reported
// modulo 512.
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // position[9:0], item_value[41:10], zero pad
    input  logic [2:0]  i_s_tuser,   // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // result_value[31:0], list_length[40:32],
                                     // status[42:41], zero pad
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_busy;
    logic              r_take;
    logic [ST_W-1:0]   r_status;
    logic [LEN_W-1:0]  r_len;
    logic              r_out_valid;
    logic [47:0]       r_out_data;

    logic [MODE_W-1:0] w_mode;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_val;
    logic [CMP_W-1:0]  w_pos_x;
    logic [CMP_W-1:0]  w_cnt_x;
    logic              w_s_acc;
    logic              w_full;
    logic [ST_W-1:0]   c_status;
    logic              c_take;
    logic              c_inc;
    logic              c_dec;
    logic [CMP_W-1:0]  c_idx;
    logic              c_do;
    logic [DATA_W-1:0] w_word;

    logic [DEPTH-1:0][DATA_W-1:0] w_data;
    logic [DEPTH-1:0][DATA_W-1:0] w_taps;

    assign w_mode  = i_s_tuser[MODE_W-1:0];
    assign w_pos   = i_s_tdata[POS_W-1:0];
    assign w_val   = i_s_tdata[POS_W+DATA_W-1:POS_W];
    assign w_pos_x = CMP_W'(w_pos);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_full  = (r_count == CW'(DEPTH));

    assign o_s_tready = i_rst_n && !r_busy && (!r_out_valid || i_m_tready);
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    always_comb begin
        c_status = ST_OK;
        c_take   = 1'b0;
        c_inc    = 1'b0;
        c_dec    = 1'b0;
        c_idx    = w_pos_x;
        unique case (w_mode)
            MODE_APPEND: begin
                if (w_full) c_status = ST_FULL;
                else        c_inc    = 1'b1;
            end
            MODE_READ: begin
                if (w_pos_x >= w_cnt_x) c_status = ST_RANGE;
                else                    c_take   = 1'b1;
            end
            MODE_OVERWRITE: begin
                if (w_pos_x >= w_cnt_x) c_status = ST_RANGE;
            end
            MODE_INSERT: begin
                if (w_pos_x > w_cnt_x) c_status = ST_RANGE;
                else if (w_full)       c_status = ST_FULL;
                else                   c_inc    = 1'b1;
            end
            MODE_REMOVE: begin
                if (w_pos_x >= w_cnt_x) begin
                    c_status = ST_RANGE;
                end else begin
                    c_take = 1'b1;
                    c_dec  = 1'b1;
                end
            end
            MODE_POP: begin
                c_idx = w_cnt_x - CMP_W'(1);
                if (r_count == '0) begin
                    c_status = ST_EMPTY;
                end else begin
                    c_take = 1'b1;
                    c_dec  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign c_do = w_s_acc && (c_status == ST_OK);

    always_comb begin
        n_count = r_count;
        if (c_do && c_inc) n_count = r_count + CW'(1);
        if (c_do && c_dec) n_count = r_count - CW'(1);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CMP_W-1:0] KX  = CMP_W'(k);
        localparam logic [CMP_W-1:0] KX1 = CMP_W'(k + 1);
        t_cell_ctrl        w_ctrl;
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;

        always_comb begin
            w_ctrl.load = c_do && (((w_mode == MODE_APPEND) && (KX == w_cnt_x)) ||
                          (((w_mode == MODE_OVERWRITE) || (w_mode == MODE_INSERT)) &&
                           (KX == w_pos_x)));
            w_ctrl.up   = c_do && (w_mode == MODE_INSERT) &&
                          (KX > w_pos_x) && (KX <= w_cnt_x);
            w_ctrl.down = c_do && (w_mode == MODE_REMOVE) &&
                          (KX >= w_pos_x) && (KX1 < w_cnt_x);
            w_ctrl.sel  = (KX == c_idx);
        end

        if (k == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_data[k+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_val   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_tap   (w_taps[k])
        );
    end

    ple_gather #(
        .DEPTH (DEPTH)
    ) u_gather (
        .i_clk  (i_clk),
        .i_load (w_s_acc),
        .i_taps (w_taps),
        .o_word (w_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= w_s_acc;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_take   <= c_take;
            r_status <= c_status;
            r_len    <= LEN_W'(n_count);
        end
        if (r_busy) begin
            r_out_data <= {5'd0, r_status, r_len, (r_take ? w_word : {DATA_W{1'b0}})};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `PLE_ASSERT_NEXT(a_one_in_flight, w_s_acc, r_busy && !o_s_tready,
        "second item taken while a gather is pending")
    `PLE_ASSERT_NEXT(a_result_follows, r_busy, o_m_tvalid,
        "result missing the cycle after the gather")
    `PLE_ASSERT_NEXT(a_error_keeps_len, w_s_acc && (c_status != ST_OK),
        r_count == $past(r_count), "failed command changed the length")
    `PLE_ASSERT_SAME(a_len_bound, 1'b1, r_count <= CW'(DEPTH),
        "length beyond capacity")

endmodule

// ===== tb/positional_list_engine_top_tb.sv =====
// Self-checking testbench for positional_list_engine_top: list commands go in as
// stream items, results are checked against an in-bench list predictor.
// Depends on ple_pkg and the engine RTL only.
`timescale 1ns / 1ps

module positional_list_engine_top_tb;
    import ple_pkg::*;

    localparam int LIST_DEPTH = 256;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_LIMIT = 20000;
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic [ST_W-1:0]   status;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;   // position[9:0], item_value[41:10], zero pad
    logic [2:0]  i_s_tuser = '0;   // mode[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // result_value[31:0], list_length[40:32],
                                   // status[42:41], zero pad

    logic [DATA_W-1:0] list_store [LIST_DEPTH];
    int                list_len = 0;
    t_list_result      expected_results [$];
    t_list_result      oldest;
    int                mismatch_count = 0;
    bit                steady = 1'b0;
    bit                hold_pending = 1'b0;

    positional_list_engine_top #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic apply_list_command(input logic [MODE_W-1:0] mode,
                                      input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] val,
                                      output t_list_result res);
        int k;
        res.value  = '0;
        res.status = ST_OK;
        case (mode)
            MODE_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_store[list_len] = val;
                    list_len++;
                end
            end
            MODE_READ: begin
                if (pos >= list_len) res.status = ST_RANGE;
                else res.value = list_store[pos];
            end
            MODE_OVERWRITE: begin
                if (pos >= list_len) res.status = ST_RANGE;
                else list_store[pos] = val;
            end
            MODE_INSERT: begin
                if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = list_len; k > pos; k--) list_store[k] = list_store[k-1];
                    list_store[pos] = val;
                    list_len++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.value = list_store[pos];
                    for (k = pos; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
                    list_len--;
                end
            end
            MODE_POP: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_store[list_len-1];
                    list_len--;
                end
            end
            default: ;
        endcase
        res.length = list_len[LEN_W-1:0];
    endtask

    task automatic push_command(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        t_list_result res;
        while (!steady && $urandom_range(0, 99) < 33) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, val, pos};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        apply_list_command(mode, pos, val, res);
        expected_results.push_back(res);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] corner [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        if ($urandom_range(0, 9) == 0) return corner[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 80) p = $urandom_range(0, list_len);
        else if (r < 90) p = list_len + $urandom_range(0, 2);
        else p = $urandom_range(0, 1023);
        return (p > 1023) ? 10'd1023 : p[POS_W-1:0];
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_count;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge i_clk);
            end else if (steady) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: tdata %h", o_m_tdata);
                mismatch_count++;
            end else begin
                oldest = expected_results.pop_front();
                if (o_m_tdata[31:0] !== oldest.value) begin
                    $error("result_value: expected %h, got %h", oldest.value, o_m_tdata[31:0]);
                    mismatch_count++;
                end
                if (o_m_tdata[40:32] !== oldest.length) begin
                    $error("list_length: expected %0d, got %0d", oldest.length,
                           o_m_tdata[40:32]);
                    mismatch_count++;
                end
                if (o_m_tdata[42:41] !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, o_m_tdata[42:41]);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        push_command(MODE_POP, 10'd0, 32'h0);
        push_command(MODE_READ, 10'd0, 32'h0);
        push_command(MODE_OVERWRITE, 10'd0, 32'h1234_5678);
        push_command(MODE_REMOVE, 10'd0, 32'h0);
        push_command(MODE_INSERT, 10'd1, 32'h5555_aaaa);
        push_command(MODE_SPARE_A, 10'd1023, 32'hffff_ffff);
        push_command(MODE_SPARE_B, 10'd512, 32'h8000_0000);
    endtask

    task automatic test_basic_commands();
        push_command(MODE_APPEND, 10'd1023, 32'h8000_0000);
        push_command(MODE_APPEND, 10'd0, 32'h7fff_ffff);
        push_command(MODE_APPEND, 10'd0, 32'h0000_0000);
        push_command(MODE_APPEND, 10'd0, 32'hffff_ffff);
        push_command(MODE_READ, 10'd0, 32'h0);
        push_command(MODE_READ, 10'd3, 32'h0);
        push_command(MODE_READ, 10'd4, 32'h0);
        push_command(MODE_READ, 10'd1023, 32'h0);
        push_command(MODE_OVERWRITE, 10'd1, 32'hdead_beef);
        push_command(MODE_OVERWRITE, 10'd4, 32'h1111_1111);
        push_command(MODE_INSERT, 10'd0, 32'h0102_0304);
        push_command(MODE_INSERT, 10'd5, 32'hcafe_f00d);
        push_command(MODE_INSERT, 10'd3, 32'h0bad_c0de);
        push_command(MODE_INSERT, 10'd8, 32'h0);
        push_command(MODE_REMOVE, 10'd0, 32'h0);
        push_command(MODE_REMOVE, 10'd5, 32'h0);
        push_command(MODE_REMOVE, 10'd2, 32'h0);
        push_command(MODE_REMOVE, 10'd5, 32'h0);
        push_command(MODE_POP, 10'd700, 32'h0);
        push_command(MODE_READ, 10'd1, 32'h0);
    endtask

    task automatic test_capacity();
        while (list_len < LIST_DEPTH)
            push_command(MODE_APPEND, POS_W'($urandom_range(0, 1023)), pick_value());
        push_command(MODE_APPEND, 10'd0, 32'h7fff_ffff);
        push_command(MODE_INSERT, 10'd1023, 32'h1);
        push_command(MODE_INSERT, 10'd256, 32'h2);
        push_command(MODE_INSERT, 10'd0, 32'h3);
        push_command(MODE_READ, 10'd255, 32'h0);
        push_command(MODE_READ, 10'd256, 32'h0);
        push_command(MODE_OVERWRITE, 10'd255, 32'h8000_0000);
        push_command(MODE_REMOVE, 10'd0, 32'h0);
        push_command(MODE_INSERT, 10'd0, 32'h4);
        push_command(MODE_REMOVE, 10'd255, 32'h0);
        push_command(MODE_INSERT, 10'd255, 32'h5);
        push_command(MODE_POP, 10'd0, 32'h0);
        while (list_len > 8) begin
            if ($urandom_range(0, 3) == 0)
                push_command(MODE_POP, POS_W'($urandom_range(0, 1023)), 32'h0);
            else
                push_command(MODE_REMOVE, POS_W'($urandom_range(0, list_len - 1)),
                             pick_value());
        end
    endtask

    task automatic test_output_hold_off();
        steady = 1'b1;
        hold_pending = 1'b1;
        repeat (40) begin
            if ($urandom_range(0, 1)) push_command(MODE_APPEND, 10'd0, pick_value());
            else push_command(MODE_READ, pick_position(), 32'h0);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_commands(input int count);
        int n;
        int r;
        bit growing;
        logic [MODE_W-1:0] mode;
        for (n = 0; n < count; n++) begin
            growing = ((n / 300) % 2) == 0;
            steady  = (n >= 200 && n < 400);
            r = $urandom_range(0, 99);
            if (r < 4) mode = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
            else if (r < 34) mode = growing ? MODE_APPEND : MODE_POP;
            else if (r < 59) mode = growing ? MODE_INSERT : MODE_REMOVE;
            else if (r < 71) mode = MODE_READ;
            else if (r < 83) mode = MODE_OVERWRITE;
            else if (r < 91) mode = growing ? MODE_REMOVE : MODE_INSERT;
            else mode = growing ? MODE_POP : MODE_APPEND;
            push_command(mode, pick_position(), pick_value());
        end
        steady = 1'b0;
    endtask

    initial begin
        int waited;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_commands();
        test_capacity();
        test_output_hold_off();
        test_random_commands(620);

        i_s_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d result items never arrived", expected_results.size());
            mismatch_count++;
        end
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
